>>> src/lpd_pkg.sv
// shared types and constants of the length-prefixed packet deframer
package lpd_pkg;

	// header layout: length at bytes 0-1, type at bytes 2-3, little-endian
	localparam int HDR_BYTES = 4;
	// size of the downstream packet buffer in bytes
	localparam int BUF_BYTES = 2048;
	// an 11-bit offset cannot go past this length
	localparam int OFFSET_LIMIT = 2048;

	localparam int BYTE_W = 8;
	localparam int OFFSET_W = 11;
	localparam int FIELD_W = 16;
	localparam int CFG_W = 12;

	// fixed cap on the length from buffer size and offset range
	localparam int LEN_CAP_INT = (BUF_BYTES < OFFSET_LIMIT) ? BUF_BYTES : OFFSET_LIMIT;
	localparam logic [CFG_W-1:0] LEN_CAP = CFG_W'(LEN_CAP_INT);

	localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(2048);

	// offset of the last header byte (offset-wide) and header size (field-wide)
	localparam logic [OFFSET_W-1:0] HDR_LAST_OFF = OFFSET_W'(HDR_BYTES - 1);
	localparam logic [FIELD_W-1:0] HDR_LEN = FIELD_W'(HDR_BYTES);

	// header byte positions of the length and type fields
	localparam logic [OFFSET_W-1:0] OFF_LEN_LO = OFFSET_W'(0);
	localparam logic [OFFSET_W-1:0] OFF_LEN_HI = OFFSET_W'(1);
	localparam logic [OFFSET_W-1:0] OFF_TYPE_LO = OFFSET_W'(2);
	localparam logic [OFFSET_W-1:0] OFF_TYPE_HI = OFFSET_W'(3);

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// one classified output beat
	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic [OFFSET_W-1:0] byte_offset;
		logic [FIELD_W-1:0]  packet_length;
		logic [FIELD_W-1:0]  packet_type;
		logic                first_byte;
		logic                last_byte;
		logic                length_error;
	} lpd_beat_t;

endpackage

>>> src/lpd_if.sv
// stream interfaces of the deframer: raw byte input and framed beat output
interface lpd_in_if import lpd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface lpd_out_if import lpd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic [OFFSET_W-1:0] byte_offset;
	logic [FIELD_W-1:0]  packet_length;
	logic [FIELD_W-1:0]  packet_type;
	logic                first_byte;
	logic                last_byte;
	logic                length_error;

	modport source (output valid, output out_byte, output byte_offset, output packet_length,
		output packet_type, output first_byte, output last_byte, output length_error,
		input ready);
	modport sink (input valid, input out_byte, input byte_offset, input packet_length,
		input packet_type, input first_byte, input last_byte, input length_error,
		output ready);
endinterface

>>> src/lpd_front.sv
// front end: accepts bytes, tracks packet offset and header fields, classifies each byte
module lpd_front import lpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  logic [BYTE_W-1:0]   byte_data,
	output logic                push_valid,
	input  logic                push_ready,
	output lpd_beat_t           push_beat
);

	logic [CFG_W-1:0]    max_len_q;
	logic [OFFSET_W-1:0] off_q;
	logic [FIELD_W-1:0]  len_q;
	logic [FIELD_W-1:0]  type_q;

	logic [FIELD_W-1:0]  len_d;
	logic [FIELD_W-1:0]  type_d;
	logic [CFG_W-1:0]    limit;
	logic [CFG_W-1:0]    off_inc;
	logic                len_match;
	logic                err;
	logic                last;
	logic [OFFSET_W-1:0] off_d;
	logic                accept;

	assign byte_ready = push_ready;
	assign push_valid = byte_valid;
	assign accept = byte_valid && push_ready;

	// length limit in use: register clipped to the fixed cap
	assign limit = (max_len_q > LEN_CAP) ? LEN_CAP : max_len_q;

	// header field capture
	always_comb begin
		len_d = len_q;
		type_d = type_q;
		if (off_q == OFF_LEN_LO) begin
			len_d = {8'h00, byte_data};
			type_d = '0;
		end else if (off_q == OFF_LEN_HI) begin
			len_d = {byte_data, len_q[7:0]};
		end else if (off_q == OFF_TYPE_LO) begin
			type_d = {8'h00, byte_data};
		end else if (off_q == OFF_TYPE_HI) begin
			type_d = {byte_data, type_q[7:0]};
		end
	end

	// end of packet and length check
	assign off_inc = {1'b0, off_q} + CFG_W'(1);
	assign len_match = ({{(FIELD_W-CFG_W){1'b0}}, off_inc} == len_d);

	always_comb begin
		err = 1'b0;
		last = 1'b0;
		if (off_q == HDR_LAST_OFF) begin
			if ((len_d < HDR_LEN) || (len_d > {{(FIELD_W-CFG_W){1'b0}}, limit})) begin
				err = 1'b1;
			end else if (len_match) begin
				last = 1'b1;
			end
		end else if ((off_q > HDR_LAST_OFF) && len_match) begin
			last = 1'b1;
		end
	end

	assign off_d = (err || last) ? '0 : off_inc[OFFSET_W-1:0];

	// classified beat
	always_comb begin
		push_beat.out_byte = byte_data;
		push_beat.byte_offset = off_q;
		push_beat.packet_length = (off_q >= OFF_LEN_HI) ? len_d : '0;
		push_beat.packet_type = (off_q >= OFF_TYPE_HI) ? type_d : '0;
		push_beat.first_byte = (off_q == OFF_LEN_LO);
		push_beat.last_byte = last;
		push_beat.length_error = err;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// packet tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			len_q <= '0;
			type_q <= '0;
		end else if (accept) begin
			off_q <= off_d;
			len_q <= len_d;
			type_q <= type_d;
		end
	end

endmodule

>>> src/lpd_queue.sv
// short beat queue decoupling the front end from the output stage
module lpd_queue import lpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  lpd_beat_t push_beat,
	output logic      pop_valid,
	input  logic      pop_ready,
	output lpd_beat_t pop_beat
);

	lpd_beat_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_beat = slot_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_beat;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + (QPTR_W+1)'(1);
				2'b01: count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/lpd_back.sv
// back end: output register that presents queued beats on the framed channel
module lpd_back import lpd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  lpd_beat_t    pop_beat,
	lpd_out_if.source    framed
);

	logic      out_valid_q;
	lpd_beat_t out_beat_q;

	// load when the register is empty or its beat is taken this cycle
	assign pop_ready = !out_valid_q || framed.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			out_beat_q <= pop_beat;
		end
	end

	// drive the channel
	assign framed.valid = out_valid_q;
	assign framed.out_byte = out_beat_q.out_byte;
	assign framed.byte_offset = out_beat_q.byte_offset;
	assign framed.packet_length = out_beat_q.packet_length;
	assign framed.packet_type = out_beat_q.packet_type;
	assign framed.first_byte = out_beat_q.first_byte;
	assign framed.last_byte = out_beat_q.last_byte;
	assign framed.length_error = out_beat_q.length_error;

endmodule

>>> src/length_prefixed_packet_deframer_core.sv
// top level of the length-prefixed packet deframer
//
// raw: byte stream in, one byte per beat (valid/ready). framed: one beat out
// per input byte, carrying the byte, its offset in the packet, the decoded
// length (from offset 1) and type (from offset 3), and first/last marks.
// Bytes 0-1 of each packet are its little-endian total length, bytes 2-3 its
// type. A length below the header size or above max_packet_len (clipped to
// the buffer size) raises length_error on the last header byte; the next byte
// then starts a new packet.
// Throughput: one byte per clock while the queue has room; the front end
// updates its offset register on each accepted byte. An accepted byte is
// written to the queue and then loaded into the output register for framed.
// cfg_we/cfg_wdata write max_packet_len; write only while the block is idle.
// Reset clears the queue and output register, sets the offset to packet
// start and max_packet_len to 2048. When framed stalls, the output register
// holds and the four-entry queue fills; raw.ready drops only when it is full.
module length_prefixed_packet_deframer_core import lpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	lpd_in_if.sink           raw,
	lpd_out_if.source        framed
);

	logic      push_valid;
	logic      push_ready;
	lpd_beat_t push_beat;
	logic      pop_valid;
	logic      pop_ready;
	lpd_beat_t pop_beat;

	// classification
	lpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.byte_valid (raw.valid),
		.byte_ready (raw.ready),
		.byte_data  (raw.in_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_beat  (push_beat)
	);

	// decoupling queue
	lpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_beat  (push_beat),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_beat   (pop_beat)
	);

	// output stage
	lpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_beat  (pop_beat),
		.framed    (framed)
	);

endmodule

>>> src/lpd_checker.sv
// port-level checks of the deframer, bound to the top level
module lpd_checker import lpd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                valid,
	input logic                ready,
	input logic [BYTE_W-1:0]   out_byte,
	input logic [OFFSET_W-1:0] byte_offset,
	input logic [FIELD_W-1:0]  packet_length,
	input logic [FIELD_W-1:0]  packet_type,
	input logic                first_byte,
	input logic                last_byte,
	input logic                length_error
);

	// first mark exactly at offset zero
	a_first_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (first_byte == (byte_offset == '0)))
		else $error("first_byte does not match offset zero");

	// a rejected length is flagged only on the last header byte and never carries the last mark
	a_error_place: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && length_error) |-> (!last_byte && (byte_offset == HDR_LAST_OFF)))
		else $error("length_error on wrong byte or with last_byte");

	// nothing decoded yet at a packet start
	a_start_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && (byte_offset == '0)) |-> ((packet_length == '0) && (packet_type == '0)))
		else $error("length or type nonzero at packet start");

	// a stalled beat stays valid and keeps its byte, offset, length and last mark
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !ready) |=> (valid && $stable(out_byte) && $stable(byte_offset)
			&& $stable(packet_length) && $stable(last_byte)))
		else $error("output beat changed while stalled");

endmodule

bind length_prefixed_packet_deframer_core lpd_checker u_lpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (framed.valid),
	.ready         (framed.ready),
	.out_byte      (framed.out_byte),
	.byte_offset   (framed.byte_offset),
	.packet_length (framed.packet_length),
	.packet_type   (framed.packet_type),
	.first_byte    (framed.first_byte),
	.last_byte     (framed.last_byte),
	.length_error  (framed.length_error)
);
